/* src/irn_pkg.sv */
// Shared types and constants for the inverse residual norm unit.
// No dependencies; every other file of the block imports this package.
package irn_pkg;

   localparam int CMD_W   = 2;
   localparam int POS_W   = 4;
   localparam int VALUE_W = 32;
   localparam int NORM_W  = 48;
   localparam int ORDER_W = 5;

   localparam logic [ORDER_W-1:0] ORDER_RESET = 5'd16;

   // Cycles from the register that catches the last memory read of a
   // compute to the cycle in which the running maximum is final.
   localparam int DRAIN_CYCLES = 5;
   localparam int DRAIN_W      = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD_A  = 2'd0,
      CMD_LOAD_X  = 2'd1,
      CMD_COMPUTE = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic wr_a;
      logic wr_x;
      logic clear;
      logic issue;
      logic first_term;
      logic last_term;
      logic diag;
      logic last_col;
      logic load_out;
   } ctl_type;

   // Tag that travels with a product through the datapath pipeline.
   typedef struct packed {
      logic valid;
      logic first_term;
      logic last_term;
      logic diag;
      logic last_col;
   } tag_type;

endpackage

/* src/irn_req_if.sv */
// Request channel of the inverse residual norm unit: valid/ready plus one item.
// Depends on irn_pkg for the field widths.
interface irn_req_if;
   import irn_pkg::*;

   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [POS_W-1:0]   row;
   logic [POS_W-1:0]   col;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output cmd, output row, output col, output value,
                   input ready);
   modport sink   (input valid, input cmd, input row, input col, input value,
                   output ready);
endinterface

/* src/irn_rsp_if.sv */
// Response channel of the inverse residual norm unit: valid/ready plus one item.
// Depends on irn_pkg for the field widths.
interface irn_rsp_if;
   import irn_pkg::*;

   logic              valid;
   logic              ready;
   logic [NORM_W-1:0] norm;
   logic              saturated;

   modport source (output valid, output norm, output saturated, input ready);
   modport sink   (input valid, input norm, input saturated, output ready);
endinterface

/* src/irn_datapath.sv */
// Datapath of the inverse residual norm unit: the two matrix memories, the
// multiply-accumulate pipeline, row sums, running maximum and result register.
// Depends on irn_pkg.
module irn_datapath #(
   parameter int MAX_ORDER = 16,
   localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  irn_pkg::ctl_type               ctl,
   input  logic [IW-1:0]                  rd_i,
   input  logic [IW-1:0]                  rd_j,
   input  logic [IW-1:0]                  rd_l,
   input  logic [irn_pkg::POS_W-1:0]      wr_row,
   input  logic [irn_pkg::POS_W-1:0]      wr_col,
   input  logic signed [irn_pkg::VALUE_W-1:0] wr_value,
   output logic [irn_pkg::NORM_W-1:0]     norm,
   output logic                           saturated
);
   import irn_pkg::*;

   localparam int DEPTH  = 1 << (2 * IW);
   localparam int PROD_W = 2 * VALUE_W;
   localparam int ACC_W  = PROD_W + IW + 1;
   localparam int Q_W    = ACC_W - 16;

   logic [VALUE_W-1:0] mem_a [DEPTH];
   logic [VALUE_W-1:0] mem_x [DEPTH];

   logic [IW+POS_W-1:0] wr_row_ext, wr_col_ext;
   logic [2*IW-1:0]     wr_addr;

   logic signed [VALUE_W-1:0] a_rd_ff, x_rd_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   tag_type                   t1_ff, t2_ff, t3_ff;

   logic signed [ACC_W-1:0]   acc_bias;
   logic signed [Q_W-1:0]     q_full;
   logic [Q_W-32:0]           q_high;
   logic                      q_fits;
   logic signed [VALUE_W-1:0] q_clip;
   logic [VALUE_W-1:0]        mag_in;

   logic [VALUE_W-1:0] mag_ff;
   logic               s4_valid_ff, s4_last_col_ff;
   logic [NORM_W-1:0]  rowsum_ff, row_total_ff, best_ff, row_sum;
   logic               row_done_ff, sat_ff;
   logic [NORM_W-1:0]  norm_ff;
   logic               sat_out_ff;

   assign wr_row_ext = {{IW{1'b0}}, wr_row};
   assign wr_col_ext = {{IW{1'b0}}, wr_col};
   assign wr_addr    = {wr_row_ext[IW-1:0], wr_col_ext[IW-1:0]};

   // Memories: writes only while idle; reads happen every cycle but matter only while a compute runs.
   always_ff @(posedge clock) begin
      if (ctl.wr_a) begin
         mem_a[wr_addr] <= wr_value;
      end
      if (ctl.wr_x) begin
         mem_x[wr_addr] <= wr_value;
      end
      a_rd_ff <= mem_a[{rd_i, rd_l}];
      x_rd_ff <= mem_x[{rd_l, rd_j}];
      prod_ff <= a_rd_ff * x_rd_ff;
      acc_ff  <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff <= '0;
         t2_ff <= '0;
         t3_ff <= '0;
      end else begin
         t1_ff <= '{valid: ctl.issue, first_term: ctl.first_term, last_term: ctl.last_term,
                    diag: ctl.diag, last_col: ctl.last_col};
         t2_ff <= t1_ff;
         t3_ff <= t2_ff;
      end
   end

   // Exact sum of Q32.32 products for one residual entry.
   always_comb begin
      if (t2_ff.first_term) begin
         acc_in = ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   // Subtract 1.0 on the diagonal, floor to Q16.16, clip to 32 bits.
   always_comb begin
      acc_bias = acc_ff - (t3_ff.diag ? (ACC_W'(1) <<< 32) : ACC_W'(0));
      q_full   = acc_bias[ACC_W-1:16];
      q_high   = q_full[Q_W-1:31];
      q_fits   = (&q_high) || !(|q_high);
      if (q_fits) begin
         q_clip = q_full[VALUE_W-1:0];
      end else if (q_full[Q_W-1]) begin
         q_clip = {1'b1, {(VALUE_W-1){1'b0}}};
      end else begin
         q_clip = {1'b0, {(VALUE_W-1){1'b1}}};
      end
      mag_in = q_clip[VALUE_W-1] ? VALUE_W'(-q_clip) : VALUE_W'(q_clip);
   end

   assign row_sum = rowsum_ff + NORM_W'(mag_ff);

   // Row sums cannot exceed MAX_ORDER * 2^31, well inside 48 bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff    <= 1'b0;
         s4_last_col_ff <= 1'b0;
         row_done_ff    <= 1'b0;
      end else begin
         s4_valid_ff    <= t3_ff.valid && t3_ff.last_term;
         s4_last_col_ff <= t3_ff.last_col;
         row_done_ff    <= s4_valid_ff && s4_last_col_ff;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      row_total_ff <= row_sum;
      if (ctl.clear) begin
         rowsum_ff <= '0;
         best_ff   <= '0;
         sat_ff    <= 1'b0;
      end else begin
         if (t3_ff.valid && t3_ff.last_term && !q_fits) begin
            sat_ff <= 1'b1;
         end
         if (s4_valid_ff) begin
            rowsum_ff <= s4_last_col_ff ? '0 : row_sum;
         end
         if (row_done_ff && (row_total_ff > best_ff)) begin
            best_ff <= row_total_ff;
         end
      end
      if (ctl.load_out) begin
         norm_ff    <= best_ff;
         sat_out_ff <= sat_ff;
      end
   end

   assign norm      = norm_ff;
   assign saturated = sat_out_ff;

endmodule

/* src/irn_controller.sv */
// Controller of the inverse residual norm unit: load decode, the i/j/l
// sequencer of a compute, pipeline drain and the response valid flag.
// Depends on irn_pkg.
module irn_controller #(
   parameter int MAX_ORDER = 16,
   localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [irn_pkg::CMD_W-1:0]    req_cmd,
   input  logic [irn_pkg::POS_W-1:0]    req_row,
   input  logic [irn_pkg::POS_W-1:0]    req_col,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [irn_pkg::ORDER_W-1:0]  n_in_use,
   output irn_pkg::ctl_type             ctl,
   output logic [IW-1:0]                rd_i,
   output logic [IW-1:0]                rd_j,
   output logic [IW-1:0]                rd_l
);
   import irn_pkg::*;

   state_type          state_ff, state_in;
   logic [IW-1:0]      i_ff, i_in, j_ff, j_in, l_ff, l_in;
   logic [IW-1:0]      n_last_ff, n_last_in;
   logic [DRAIN_W-1:0] drain_ff, drain_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               req_fire, in_range, out_free;
   logic               l_end, j_end, i_end;
   logic [ORDER_W-1:0] order_min;
   logic [31:0]        n_last_wide;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign in_range  = (32'(req_row) < MAX_ORDER) && (32'(req_col) < MAX_ORDER);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign l_end = (l_ff == n_last_ff);
   assign j_end = (j_ff == n_last_ff);
   assign i_end = (i_ff == n_last_ff);

   // Order zero acts as one, an order above the build maximum as the maximum.
   always_comb begin
      order_min = (n_in_use == '0) ? ORDER_W'(1) : n_in_use;
      if (32'(order_min) > MAX_ORDER) begin
         n_last_wide = 32'(MAX_ORDER - 1);
      end else begin
         n_last_wide = 32'(order_min) - 32'd1;
      end
      n_last_in = n_last_wide[IW-1:0];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_cmd == CMD_COMPUTE)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (l_end && j_end && i_end) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (drain_ff == DRAIN_W'(DRAIN_CYCLES - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctl = '0;
      case (state_ff)
         ST_IDLE: begin
            ctl.wr_a  = req_fire && (req_cmd == CMD_LOAD_A) && in_range;
            ctl.wr_x  = req_fire && (req_cmd == CMD_LOAD_X) && in_range;
            ctl.clear = req_fire && (req_cmd == CMD_COMPUTE);
         end
         ST_RUN: begin
            ctl.issue      = 1'b1;
            ctl.first_term = (l_ff == '0);
            ctl.last_term  = l_end;
            ctl.diag       = (i_ff == j_ff);
            ctl.last_col   = j_end;
         end
         ST_FINISH: begin
            ctl.load_out = out_free;
         end
         default: begin
            ctl = '0;
         end
      endcase
   end

   // Loop counters: l innermost, then column j, then row i.
   always_comb begin
      i_in = i_ff;
      j_in = j_ff;
      l_in = l_ff;
      if (state_ff == ST_IDLE) begin
         i_in = '0;
         j_in = '0;
         l_in = '0;
      end else if (state_ff == ST_RUN) begin
         l_in = l_end ? '0 : l_ff + 1'b1;
         if (l_end) begin
            j_in = j_end ? '0 : j_ff + 1'b1;
            if (j_end) begin
               i_in = i_ff + 1'b1;
            end
         end
      end
      drain_in     = (state_ff == ST_DRAIN) ? drain_ff + 1'b1 : '0;
      rsp_valid_in = ctl.load_out ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         l_ff         <= '0;
         n_last_ff    <= '0;
         drain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         l_ff         <= l_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ctl.clear) begin
            n_last_ff <= n_last_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rd_i      = i_ff;
   assign rd_j      = j_ff;
   assign rd_l      = l_ff;

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.wr_a, ctl.wr_x, ctl.issue, ctl.load_out, ctl.clear}))
      else $error("controller issued more than one datapath command");

   a_run_ends_on_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && state_in == ST_DRAIN) |-> (ctl.last_term && ctl.last_col))
      else $error("compute left the run state before its last product");

   a_out_free: assert property (@(posedge clock) disable iff (reset)
      ctl.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while a result was pending");

   a_compute_starts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_cmd == CMD_COMPUTE) |=>
         (state_ff == ST_RUN && i_ff == '0 && j_ff == '0 && l_ff == '0))
      else $error("compute did not start at the first element");

   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      ctl.issue |-> (i_ff <= n_last_ff && j_ff <= n_last_ff && l_ff <= n_last_ff))
      else $error("loop index beyond the order in use");

endmodule

/* src/inverse_residual_norm_unit.sv */
// Inverse residual norm unit: loads A and X, then reports the infinity norm of A*X - I.
// Depends on irn_pkg, irn_req_if, irn_rsp_if, irn_controller and irn_datapath.
// Load items are accepted back to back while no compute is in progress. A compute item of
// order n holds the request side while it issues one product per cycle over every i, j and l
// below n, drains the pipeline and loads the result register, which waits while an earlier
// result is still pending; its result is offered once that register is loaded. Reset
// (synchronous, active high) clears control and sets order 16.
module inverse_residual_norm_unit #(
   parameter int MAX_ORDER = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   irn_req_if.sink                       req,
   irn_rsp_if.source                     rsp,
   input  logic                          csr_we,
   input  logic [irn_pkg::ORDER_W-1:0]   csr_wdata
);
   import irn_pkg::*;

   localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

   // The order register. The user must write it only while the unit is idle; the block
   // does not enforce it. A compute latches the effective order when it is accepted.
   logic [ORDER_W-1:0] n_in_use_ff, n_in_use_in;

   ctl_type       ctl;
   logic [IW-1:0] rd_i, rd_j, rd_l;

   assign n_in_use_in = csr_we ? csr_wdata : n_in_use_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         n_in_use_ff <= ORDER_RESET;
      end else begin
         n_in_use_ff <= n_in_use_in;
      end
   end

   // The controller decodes each item. Loads of A or X go straight to the
   // memories; an out-of-range position or an unknown command is dropped.
   // A compute walks row i, column j and term l, issuing one memory read
   // pair per cycle, waits for the pipeline to drain and then moves the
   // maximum row sum into the result register. The matrix memories are
   // not cleared by reset and must be written before they are read.
   irn_controller #(
      .MAX_ORDER (MAX_ORDER)
   ) u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .req_cmd   (req.cmd),
      .req_row   (req.row),
      .req_col   (req.col),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .n_in_use  (n_in_use_ff),
      .ctl       (ctl),
      .rd_i      (rd_i),
      .rd_j      (rd_j),
      .rd_l      (rd_l)
   );

   // The datapath reads the memories, multiplies, accumulates each residual
   // entry exactly, floors it to Q16.16 with clipping, sums magnitudes per
   // row and keeps the largest row sum together with a clip flag. The
   // result register lets a finished result wait while loads continue.
   irn_datapath #(
      .MAX_ORDER (MAX_ORDER)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .rd_i      (rd_i),
      .rd_j      (rd_j),
      .rd_l      (rd_l),
      .wr_row    (req.row),
      .wr_col    (req.col),
      .wr_value  (req.value),
      .norm      (rsp.norm),
      .saturated (rsp.saturated)
   );

endmodule

/* sim/irn_checker.sv */
// Result checker for the inverse residual norm unit: mirrors both matrix stores and the
// order register, predicts the norm of every compute item and compares each result.
// Depends on irn_pkg, irn_req_if and irn_rsp_if.
module irn_checker #(
   parameter int MAX_ORDER = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   irn_req_if                          req,
   irn_rsp_if                          rsp,
   input  logic                        csr_we,
   input  logic [irn_pkg::ORDER_W-1:0] csr_wdata,
   output int unsigned                 pending,
   output int unsigned                 errors
);
   import irn_pkg::*;

   // Wide enough for sixteen exact Q32.32 products.
   localparam int ACC_W = 80;
   localparam logic signed [ACC_W-1:0] Q_MAX = 80'sh7FFF_FFFF;
   localparam logic signed [ACC_W-1:0] Q_MIN = -80'sh8000_0000;
   localparam logic signed [ACC_W-1:0] Q_ONE = 80'sh1_0000;
   localparam logic [63:0] NORM_LIMIT = 64'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic [NORM_W-1:0] norm;
      logic              saturated;
   } norm_result_type;

   logic [VALUE_W-1:0] a_entries [MAX_ORDER*MAX_ORDER];
   logic [VALUE_W-1:0] x_entries [MAX_ORDER*MAX_ORDER];
   logic [ORDER_W-1:0] order_reg;
   norm_result_type    expected_norms [$];

   // Infinity norm of A*X - I over the corner selected by the order register.
   function automatic norm_result_type residual_norm();
      int unsigned n;
      logic signed [ACC_W-1:0] dot, fa, fx, q;
      logic [63:0] row_sum, best;
      norm_result_type res;
      n = order_reg;
      if (n == 0) n = 1;
      if (n > MAX_ORDER) n = MAX_ORDER;
      best = '0;
      res.saturated = 1'b0;
      for (int i = 0; i < n; i++) begin
         row_sum = '0;
         for (int j = 0; j < n; j++) begin
            dot = '0;
            for (int l = 0; l < n; l++) begin
               fa = $signed(a_entries[i*MAX_ORDER+l]);
               fx = $signed(x_entries[l*MAX_ORDER+j]);
               dot += fa * fx;
            end
            // The arithmetic shift rounds toward minus infinity.
            q = dot >>> 16;
            if (i == j) q -= Q_ONE;
            if (q > Q_MAX) begin
               q = Q_MAX;
               res.saturated = 1'b1;
            end else if (q < Q_MIN) begin
               q = Q_MIN;
               res.saturated = 1'b1;
            end
            row_sum += (q < 0) ? 64'(-q) : 64'(q);
         end
         if (row_sum > NORM_LIMIT) begin
            row_sum = NORM_LIMIT;
            res.saturated = 1'b1;
         end
         if (row_sum > best) best = row_sum;
      end
      res.norm = best[NORM_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      norm_result_type want;
      if (reset) begin
         order_reg = ORDER_RESET;
      end else begin
         if (csr_we) order_reg = csr_wdata;
         if (req.valid && req.ready) begin
            case (cmd_type'(req.cmd))
               CMD_LOAD_A: begin
                  if (req.row < MAX_ORDER && req.col < MAX_ORDER)
                     a_entries[req.row*MAX_ORDER+req.col] = req.value;
               end
               CMD_LOAD_X: begin
                  if (req.row < MAX_ORDER && req.col < MAX_ORDER)
                     x_entries[req.row*MAX_ORDER+req.col] = req.value;
               end
               CMD_COMPUTE: expected_norms.push_back(residual_norm());
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_norms.size() == 0) begin
               $error("unexpected result: norm %0h saturated %0b", rsp.norm, rsp.saturated);
               errors++;
            end else begin
               want = expected_norms.pop_front();
               if (rsp.norm !== want.norm) begin
                  $error("norm: expected %0h, actual %0h", want.norm, rsp.norm);
                  errors++;
               end
               if (rsp.saturated !== want.saturated) begin
                  $error("saturated: expected %0b, actual %0b", want.saturated, rsp.saturated);
                  errors++;
               end
            end
         end
      end
      pending = expected_norms.size();
   end

endmodule

/* sim/inverse_residual_norm_unit_tb.sv */
// Top of the inverse residual norm unit testbench: clock, reset, stimulus and verdict.
// Depends on irn_pkg, irn_req_if, irn_rsp_if, irn_checker and the unit itself.
module inverse_residual_norm_unit_tb;
   import irn_pkg::*;

   localparam int MAX_ORDER = 16;
   // A compute of order 16 keeps both channels quiet for its whole run; the
   // watchdog allows several times that quiet spell before it calls the run hung.
   localparam int unsigned WATCHDOG_LIMIT = 25000;
   // Cycles to let a load or the result drain settle before touching the register.
   localparam int unsigned SETTLE_CYCLES = DRAIN_CYCLES + 8;
   localparam int unsigned TARGET_ITEMS = 650;
   localparam int unsigned TARGET_COMPUTES = 48;

   // How the two sides of the block pace themselves during a phase.
   typedef enum int {
      PACE_STEADY,
      PACE_SEND_GAPS,
      PACE_RECV_STALLS,
      PACE_BOTH
   } pace_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [ORDER_W-1:0] csr_wdata;

   irn_req_if req_ch ();
   irn_rsp_if rsp_ch ();

   int unsigned pending;
   int unsigned errors;
   int unsigned quiet_cycles;
   int unsigned items_sent;
   int unsigned computes_sent;
   pace_type    pace;

   // Which store entries have been written; a compute never reads beyond these.
   bit a_loaded [MAX_ORDER*MAX_ORDER];
   bit x_loaded [MAX_ORDER*MAX_ORDER];

   inverse_residual_norm_unit #(
      .MAX_ORDER (MAX_ORDER)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   irn_checker #(
      .MAX_ORDER (MAX_ORDER)
   ) u_checker (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .pending   (pending),
      .errors    (errors)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Percentages of cycles in which the sender holds back or the receiver stalls.
   function automatic int unsigned send_gap_pct(pace_type p);
      case (p)
         PACE_SEND_GAPS: return 63;
         PACE_BOTH:      return 23;
         default:        return 0;
      endcase
   endfunction

   function automatic int unsigned recv_stall_pct(pace_type p);
      case (p)
         PACE_RECV_STALLS: return 63;
         PACE_BOTH:        return 23;
         default:          return 0;
      endcase
   endfunction

   // An order code of zero behaves as one, and codes above the built size behave as it.
   function automatic int unsigned effective_order(logic [ORDER_W-1:0] code);
      if (code == 0) return 1;
      if (code > MAX_ORDER) return MAX_ORDER;
      return code;
   endfunction

   // Element values by phase flavor. Flavor 0 builds near-identity matrices so that X is
   // close to the inverse of A and the residual stays small and unsaturated. Flavor 1 uses
   // modest values and flavor 2 spans the whole Q16.16 range, both with the extremes mixed in.
   function automatic logic [VALUE_W-1:0] pick_value(int unsigned flavor, bit on_diag);
      int unsigned roll;
      logic [VALUE_W-1:0] v;
      roll = $urandom_range(0, 99);
      if (flavor != 0 && roll < 4) v = 32'h7FFF_FFFF;
      else if (flavor != 0 && roll < 8) v = 32'h8000_0000;
      else if (flavor != 0 && roll < 10) v = '0;
      else begin
         case (flavor)
            0: v = (on_diag ? 32'h0001_0000 : 32'h0) + $urandom_range(0, 511) - 32'd256;
            1: v = $urandom_range(0, 32'h0007_FFFF) - 32'h0004_0000;
            default: v = $urandom;
         endcase
      end
      return v;
   endfunction

   // Receiver side: ready is redrawn at every falling edge according to the phase pacing.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct(pace));
      end
   end

   // Watchdog: any accepted item on either channel restarts the count of quiet cycles.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one item and returns at the falling edge after it was accepted. It is entered
   // at a falling edge; random gaps keep valid low before the item goes out. Valid stays
   // high on return so that back-to-back items never drop it within one time step.
   task automatic send_item(input cmd_type op, input logic [POS_W-1:0] r,
                            input logic [POS_W-1:0] c, input logic [VALUE_W-1:0] v);
      int unsigned slot;
      while ($urandom_range(0, 99) < send_gap_pct(pace)) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd   <= op;
      req_ch.row   <= r;
      req_ch.col   <= c;
      req_ch.value <= v;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      slot = r * MAX_ORDER + c;
      case (op)
         CMD_LOAD_A:  a_loaded[slot] = 1'b1;
         CMD_LOAD_X:  x_loaded[slot] = 1'b1;
         CMD_COMPUTE: computes_sent++;
         default: ;
      endcase
      if (op != CMD_NONE) items_sent++;
      @(negedge clock);
   endtask

   // Brings the block to rest: no item offered, every result collected, and enough spare
   // cycles for a trailing load or the last drain to finish.
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_order(input logic [ORDER_W-1:0] code);
      settle();
      csr_we    <= 1'b1;
      csr_wdata <= code;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Writes every element of the leading n-by-n corner that has not been written yet,
   // so that the next compute reads only defined entries.
   task automatic fill_corner(input int unsigned n, input int unsigned flavor);
      for (int r = 0; r < n; r++) begin
         for (int c = 0; c < n; c++) begin
            if (!a_loaded[r*MAX_ORDER+c])
               send_item(CMD_LOAD_A, POS_W'(r), POS_W'(c), pick_value(flavor, r == c));
            if (!x_loaded[r*MAX_ORDER+c])
               send_item(CMD_LOAD_X, POS_W'(r), POS_W'(c), pick_value(flavor, r == c));
         end
      end
   endtask

   // Random traffic once the corner is complete: mostly loads that reshape the corner,
   // some loads anywhere in the stores, a quarter computes, and a few unknown commands.
   task automatic run_mix(input int unsigned n, input int unsigned flavor,
                          input int unsigned count);
      int unsigned done;
      int unsigned roll;
      logic [POS_W-1:0] r, c;
      cmd_type op;
      done = 0;
      while (done < count) begin
         roll = $urandom_range(0, 99);
         if (roll < 5) begin
            send_item(CMD_NONE, POS_W'($urandom), POS_W'($urandom), $urandom);
         end else if (roll < 30) begin
            send_item(CMD_COMPUTE, POS_W'($urandom), POS_W'($urandom), $urandom);
            done++;
         end else begin
            op = ($urandom_range(0, 1) != 0) ? CMD_LOAD_X : CMD_LOAD_A;
            if ($urandom_range(0, 3) != 0) begin
               r = POS_W'($urandom_range(0, n - 1));
               c = POS_W'($urandom_range(0, n - 1));
            end else begin
               r = POS_W'($urandom);
               c = POS_W'($urandom);
            end
            send_item(op, r, c, pick_value(flavor, r == c));
            done++;
         end
      end
   endtask

   // Order codes stepped through by the random phases. They cover the smallest order,
   // zero, the built maximum and codes beyond it, so that every register bit toggles.
   function automatic logic [ORDER_W-1:0] phase_order(int unsigned phase);
      case (phase % 12)
         0:  return 5'd2;
         1:  return 5'd1;
         2:  return 5'd4;
         3:  return 5'd0;
         4:  return 5'd3;
         5:  return 5'd16;
         6:  return 5'd5;
         7:  return 5'd31;
         8:  return 5'd8;
         9:  return 5'd12;
         10: return 5'd17;
         default: return 5'd6;
      endcase
   endfunction

   initial begin
      int unsigned phase;
      int unsigned n;
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_wdata     = '0;
      req_ch.valid  = 1'b0;
      req_ch.cmd    = CMD_LOAD_A;
      req_ch.row    = '0;
      req_ch.col    = '0;
      req_ch.value  = '0;
      pace          = PACE_STEADY;
      items_sent    = 0;
      computes_sent = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at order one, where only element (0,0) of each store is read.
      set_order(5'd1);
      // Largest positive operands: the entry clips to the top of Q16.16.
      send_item(CMD_LOAD_A, 4'd0, 4'd0, 32'h7FFF_FFFF);
      send_item(CMD_LOAD_X, 4'd0, 4'd0, 32'h7FFF_FFFF);
      send_item(CMD_COMPUTE, 4'd0, 4'd0, 32'h0);
      // Two most negative operands give the largest possible product.
      send_item(CMD_LOAD_A, 4'd0, 4'd0, 32'h8000_0000);
      send_item(CMD_LOAD_X, 4'd0, 4'd0, 32'h8000_0000);
      send_item(CMD_COMPUTE, 4'd15, 4'd15, 32'hFFFF_FFFF);
      // Opposite extremes: the entry clips to the bottom of Q16.16.
      send_item(CMD_LOAD_X, 4'd0, 4'd0, 32'h7FFF_FFFF);
      send_item(CMD_COMPUTE, 4'd0, 4'd0, 32'h0);
      // One times one cancels the identity exactly, so the norm is zero.
      send_item(CMD_LOAD_A, 4'd0, 4'd0, 32'h0001_0000);
      send_item(CMD_LOAD_X, 4'd0, 4'd0, 32'h0001_0000);
      send_item(CMD_COMPUTE, 4'd0, 4'd0, 32'h0);
      // A tiny negative product must truncate toward minus infinity, not toward zero.
      send_item(CMD_LOAD_A, 4'd0, 4'd0, 32'hFFFF_FFFF);
      send_item(CMD_LOAD_X, 4'd0, 4'd0, 32'h0000_0001);
      send_item(CMD_COMPUTE, 4'd0, 4'd0, 32'h0);
      // An unknown command is dropped without a result.
      send_item(CMD_NONE, 4'd15, 4'd15, 32'h8000_0000);
      // Loads at the far corner of the stores, outside what order one reads.
      send_item(CMD_LOAD_A, 4'd15, 4'd15, 32'h0);
      send_item(CMD_LOAD_X, 4'd15, 4'd0, 32'h7FFF_FFFF);
      // An order code of zero must behave as order one.
      set_order(5'd0);
      send_item(CMD_COMPUTE, 4'd0, 4'd0, 32'h0);

      // Random phases. Each one sets an order while idle, completes the corner that
      // order reads, and then runs mixed traffic under one of the four pacing styles.
      phase = 0;
      while (items_sent < TARGET_ITEMS || computes_sent < TARGET_COMPUTES) begin
         set_order(phase_order(phase));
         pace = pace_type'(phase % 4);
         n = effective_order(phase_order(phase));
         fill_corner(n, phase % 3);
         run_mix(n, phase % 3, $urandom_range(15, 25));
         phase++;
      end

      settle();
      if (errors == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
